// ===== design/lcps_pkg.sv =====
`timescale 1ns / 1ps

package lcps_pkg;

    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned LED_W     = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 16'd500;
    localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 16'd1000;

    localparam logic [LED_W-1:0] LED_ALL_ON     = 8'hFF;
    localparam logic [LED_W-1:0] SINGLE_FIRST   = 8'h7F;
    localparam logic [LED_W-1:0] SINGLE_FILL    = 8'h80;
    localparam logic [LED_W-1:0] SINGLE_LAST    = 8'hFE;
    localparam logic [LED_W-1:0] DOUBLE_FIRST   = 8'h3F;
    localparam logic [LED_W-1:0] DOUBLE_FILL    = 8'hC0;
    localparam logic [LED_W-1:0] HALF_LOW       = 8'h0F;
    localparam logic [LED_W-1:0] HALF_HIGH      = 8'hF0;

    localparam logic [2:0] DOUBLE_STEPS   = 3'd5;
    localparam logic [4:0] FILL_LAST_LOW  = 5'd7;
    localparam logic [4:0] FILL_STEPS     = 5'd16;

    typedef enum logic [0:0] {
        REG_SHORT_PERIOD = 1'b0,
        REG_LONG_PERIOD  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        PAT_SINGLE = 2'd0,
        PAT_DOUBLE = 2'd1,
        PAT_HALF   = 2'd2,
        PAT_FILL   = 2'd3
    } pattern_t;

    typedef enum logic [1:0] {
        HALF_LOW_STEP  = 2'd0,
        HALF_HIGH_STEP = 2'd1,
        HALF_PAUSE     = 2'd2,
        HALF_SPARE     = 2'd3
    } half_step_t;

    typedef struct packed {
        logic short_fire;
        logic long_fire;
    } fire_t;

    typedef struct packed {
        logic [LED_W-1:0] led;
        logic             updated;
        pattern_t         mode_next;
        pattern_t         mode_now;
    } core_res_t;

endpackage

// ===== design/lcps_if.sv =====
`timescale 1ns / 1ps

interface lcps_tick_if;
    logic valid;
    logic ready;
    logic tick_valid;

    modport source (output valid, output tick_valid, input ready);
    modport sink   (input valid, input tick_valid, output ready);
endinterface

interface lcps_led_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_pins;
    logic       led_updated;
    logic [1:0] pattern_index;

    modport source (output valid, output led_pins, output led_updated,
                    output pattern_index, input ready);
    modport sink   (input valid, input led_pins, input led_updated,
                    input pattern_index, output ready);
endinterface

// ===== design/led_chaser_pattern_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Beat
// ticks    in   tick_valid
// leds     out  led_pins, led_updated, pattern_index
// wr_*     in   period register write (index 0 short, 1 long)
//
// One beat per cycle sustained while leds.ready holds; a taken beat reaches leds through
// the input register and the result register, with one pass of counter/pattern logic
// between them.
// Reset clears counters and pattern state and sets the periods to 500 / 1000.
// A stalled leds beat holds; ticks keep being taken until the input register fills.

module led_chaser_pattern_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    lcps_tick_if.sink                      ticks,
    lcps_led_if.source                     leds,
    input  logic                           wr_en,
    input  logic [lcps_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lcps_pkg::PERIOD_W-1:0]  wr_data
);
    import lcps_pkg::*;

    logic             in_valid_reg;
    logic             in_tick_reg;
    logic             out_valid_reg;
    logic [LED_W-1:0] out_led_reg;
    logic             out_upd_reg;
    pattern_t         out_mode_reg;
    logic             advance;
    fire_t            fire;
    core_res_t        res;

    assign advance     = in_valid_reg && (!out_valid_reg || leds.ready);
    assign ticks.ready = !in_valid_reg || advance;

    lcps_tick_timer u_timer (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .step     (advance),
        .tick     (in_tick_reg),
        .fire     (fire)
    );

    lcps_pattern_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .fire  (fire),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ticks.ready)
                in_valid_reg <= ticks.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (leds.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ticks.ready && ticks.valid)
            in_tick_reg <= ticks.tick_valid;
        if (advance)
        begin
            out_led_reg  <= res.led;
            out_upd_reg  <= res.updated;
            out_mode_reg <= res.mode_next;
        end
    end

    assign leds.valid         = out_valid_reg;
    assign leds.led_pins      = out_led_reg;
    assign leds.led_updated   = out_upd_reg;
    assign leds.pattern_index = out_mode_reg;

    a_no_tick_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_tick_reg |=> !leds.led_updated)
        else $error("beat without tick reported an LED write");

    a_mode_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (leds.pattern_index == $past(res.mode_now)) ||
                    (leds.pattern_index == $past(res.mode_now) + 2'd1))
        else $error("pattern advanced by more than one");

    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !leds.ready |-> !ticks.ready)
        else $error("tick taken while both stages held");

    a_result_follows_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> leds.valid)
        else $error("advanced beat did not reach the output");

endmodule

// ===== design/lcps_tick_timer.sv =====
`timescale 1ns / 1ps

module lcps_tick_timer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [lcps_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [lcps_pkg::PERIOD_W-1:0]    wr_data,
    input  logic                             step,
    input  logic                             tick,
    output lcps_pkg::fire_t                  fire
);
    import lcps_pkg::*;

    logic [PERIOD_W-1:0] short_period_reg;
    logic [PERIOD_W-1:0] long_period_reg;
    logic [PERIOD_W-1:0] short_cnt_reg;
    logic [PERIOD_W-1:0] long_cnt_reg;
    logic [PERIOD_W-1:0] short_cnt_next;
    logic [PERIOD_W-1:0] long_cnt_next;
    logic [PERIOD_W-1:0] short_sum;
    logic [PERIOD_W-1:0] long_sum;

    assign short_sum = short_cnt_reg + 1'b1;
    assign long_sum  = long_cnt_reg + 1'b1;

    assign fire.short_fire = tick && (short_sum >= short_period_reg);
    assign fire.long_fire  = tick && (long_sum >= long_period_reg);

    always_comb
    begin
        short_cnt_next = short_cnt_reg;
        long_cnt_next  = long_cnt_reg;
        if (tick)
        begin
            short_cnt_next = fire.short_fire ? '0 : short_sum;
            long_cnt_next  = fire.long_fire ? '0 : long_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_period_reg <= SHORT_PERIOD_RST;
            long_period_reg  <= LONG_PERIOD_RST;
            short_cnt_reg    <= '0;
            long_cnt_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (reg_index_t'(wr_index))
                    REG_SHORT_PERIOD: short_period_reg <= wr_data;
                    REG_LONG_PERIOD:  long_period_reg  <= wr_data;
                    default:          ;
                endcase
            end
            if (step)
            begin
                short_cnt_reg <= short_cnt_next;
                long_cnt_reg  <= long_cnt_next;
            end
        end
    end

endmodule

// ===== design/lcps_pattern_core.sv =====
`timescale 1ns / 1ps

module lcps_pattern_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  lcps_pkg::fire_t    fire,
    output lcps_pkg::core_res_t res
);
    import lcps_pkg::*;

    pattern_t         mode_reg,   mode_next;
    logic [LED_W-1:0] single_reg, single_next;
    logic [LED_W-1:0] double_reg, double_next;
    logic [LED_W-1:0] fill_reg,   fill_next;
    logic [2:0]       dcnt_reg,   dcnt_next;
    half_step_t       hcnt_reg,   hcnt_next;
    logic [4:0]       fcnt_reg,   fcnt_next;
    logic [LED_W-1:0] led_reg,    led_next;
    logic             wrote;

    always_comb
    begin
        mode_next   = mode_reg;
        single_next = single_reg;
        double_next = double_reg;
        fill_next   = fill_reg;
        dcnt_next   = dcnt_reg;
        hcnt_next   = hcnt_reg;
        fcnt_next   = fcnt_reg;
        led_next    = led_reg;
        wrote       = 1'b0;

        if (fire.short_fire)
        begin
            unique case (mode_reg)
                PAT_SINGLE:
                begin
                    single_next = (single_reg == LED_ALL_ON) ? SINGLE_FIRST
                                : ((single_reg >> 1) | SINGLE_FILL);
                    led_next = single_next;
                    wrote    = 1'b1;
                    if (single_next == SINGLE_LAST)
                    begin
                        single_next = LED_ALL_ON;
                        mode_next   = PAT_DOUBLE;
                    end
                end
                PAT_DOUBLE:
                begin
                    double_next = (double_reg == LED_ALL_ON) ? DOUBLE_FIRST
                                : ((double_reg >> 2) | DOUBLE_FILL);
                    led_next  = double_next;
                    wrote     = 1'b1;
                    dcnt_next = dcnt_reg + 1'b1;
                    if (dcnt_next == DOUBLE_STEPS)
                    begin
                        double_next = LED_ALL_ON;
                        dcnt_next   = '0;
                        mode_next   = PAT_HALF;
                    end
                end
                PAT_FILL:
                begin
                    priority if (fcnt_reg <= FILL_LAST_LOW)
                    begin
                        fill_next = fill_reg >> 1;
                        led_next  = fill_next;
                        wrote     = 1'b1;
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    else if (fcnt_reg < FILL_STEPS)
                    begin
                        fill_next = (fill_reg >> 1) | SINGLE_FILL;
                        led_next  = fill_next;
                        wrote     = 1'b1;
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    else
                    begin
                        fcnt_next = '0;
                        mode_next = PAT_SINGLE;
                    end
                end
                PAT_HALF: ;
                default: ;
            endcase
        end

        // long branch sees the mode left by the short branch
        if (fire.long_fire && mode_next == PAT_HALF)
        begin
            unique case (hcnt_reg)
                HALF_LOW_STEP:
                begin
                    led_next  = HALF_LOW;
                    wrote     = 1'b1;
                    hcnt_next = HALF_HIGH_STEP;
                end
                HALF_HIGH_STEP:
                begin
                    led_next  = HALF_HIGH;
                    wrote     = 1'b1;
                    hcnt_next = HALF_PAUSE;
                end
                HALF_PAUSE, HALF_SPARE:
                begin
                    hcnt_next = HALF_LOW_STEP;
                    mode_next = PAT_FILL;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.led       = led_next;
        res.updated   = wrote;
        res.mode_next = mode_next;
        res.mode_now  = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= PAT_SINGLE;
            single_reg <= LED_ALL_ON;
            double_reg <= LED_ALL_ON;
            fill_reg   <= LED_ALL_ON;
            dcnt_reg   <= '0;
            hcnt_reg   <= HALF_LOW_STEP;
            fcnt_reg   <= '0;
            led_reg    <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            single_reg <= single_next;
            double_reg <= double_next;
            fill_reg   <= fill_next;
            dcnt_reg   <= dcnt_next;
            hcnt_reg   <= hcnt_next;
            fcnt_reg   <= fcnt_next;
            led_reg    <= led_next;
        end
    end

endmodule
